// ===== rtl/thread_ready_queue_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thread ready queue scheduler
// Shared concurrent assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef THREAD_READY_QUEUE_SCHEDULER_MACROS_SVH
`define THREAD_READY_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define TRQS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define TRQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== rtl/trqs_pkg.sv =====
// ----------------------------------------------------------------------------
// trqs_pkg
// Types, codes and helper functions of the thread ready queue scheduler.
// ----------------------------------------------------------------------------
package trqs_pkg;

    localparam int MAX_THREADS = 16;
    localparam int IDX_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);

    localparam int TID_W   = 4;
    localparam int NS_W    = 3;
    localparam int REQ_W   = 3;
    localparam int TICK_W  = 32;
    localparam int BT_W    = 16;
    localparam int CNTF_W  = 5;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    localparam logic [REQ_W-1:0] REQ_ADMIT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SCHED = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PURGE = 3'd4;

    localparam logic [BT_W-1:0] BACKUP_TIME_RST = 16'd10;

    typedef enum logic [2:0] {
        TS_READY   = 3'd0,
        TS_ACTIVE  = 3'd1,
        TS_SLEEP   = 3'd2,
        TS_BLOCKED = 3'd3,
        TS_DEAD    = 3'd4,
        TS_FREE    = 3'd7
    } tstate_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DISPATCH,
        FSM_SCHED_PUT,
        FSM_SCHED_TAKE,
        FSM_WALK,
        FSM_FINISH
    } fsm_t;

    typedef struct packed {
        logic latch;
        logic do_admit;
        logic do_set;
        logic sched_put;
        logic sched_take;
        logic walk_init;
        logic walk_tick;   // with walk_init: tick walk, else purge walk
        logic walk_sched;  // with walk_init: flag all_done at end
        logic walk_step;
        logic walk_end;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             ready_empty;
        logic             walk_last;
        logic             out_free;
    } status_t;

    // circular pointer advance, b below MAX_THREADS
    function automatic logic [IDX_W-1:0] ptr_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (sum >= (CNT_W+1)'(MAX_THREADS))
            sum = sum - (CNT_W+1)'(MAX_THREADS);
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ptr_dec(logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0)
            r = IDX_W'(MAX_THREADS - 1);
        else
            r = a - 1'b1;
        return r;
    endfunction

    function automatic logic tid_in_range(logic [TID_W-1:0] tid);
        return (IDX_W+TID_W+1)'(tid) < (IDX_W+TID_W+1)'(MAX_THREADS);
    endfunction

    function automatic logic [IDX_W-1:0] tid_to_slot(logic [TID_W-1:0] tid);
        logic [IDX_W+TID_W-1:0] w;
        w = (IDX_W+TID_W)'(tid);
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [TID_W-1:0] slot_to_tid(logic [IDX_W-1:0] slot);
        logic [IDX_W+TID_W-1:0] w;
        w = (IDX_W+TID_W)'(slot);
        return w[TID_W-1:0];
    endfunction

    function automatic logic [CNTF_W-1:0] cnt_to_field(logic [CNT_W-1:0] c);
        logic [CNT_W+CNTF_W-1:0] w;
        w = (CNT_W+CNTF_W)'(c);
        return w[CNTF_W-1:0];
    endfunction

endpackage

// ===== rtl/trqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// trqs_ctrl
// Sequencer: steps one request through the datapath and hands off the result.
// ----------------------------------------------------------------------------
module trqs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  trqs_pkg::status_t status,
    output trqs_pkg::cmd_t    cmd
);

    trqs_pkg::fsm_t state_reg;
    trqs_pkg::fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= trqs_pkg::FSM_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            trqs_pkg::FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = trqs_pkg::FSM_DISPATCH;
                end
            end
            trqs_pkg::FSM_DISPATCH:
            begin
                priority case (status.req)
                    trqs_pkg::REQ_ADMIT:
                    begin
                        cmd.do_admit = 1'b1;
                        state_next   = trqs_pkg::FSM_FINISH;
                    end
                    trqs_pkg::REQ_SET:
                    begin
                        cmd.do_set = 1'b1;
                        state_next = trqs_pkg::FSM_FINISH;
                    end
                    trqs_pkg::REQ_SCHED:
                        state_next = trqs_pkg::FSM_SCHED_PUT;
                    trqs_pkg::REQ_TICK:
                    begin
                        cmd.walk_init = 1'b1;
                        cmd.walk_tick = 1'b1;
                        state_next    = trqs_pkg::FSM_WALK;
                    end
                    trqs_pkg::REQ_PURGE:
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = trqs_pkg::FSM_WALK;
                    end
                    default:
                        state_next = trqs_pkg::FSM_FINISH;
                endcase
            end
            trqs_pkg::FSM_SCHED_PUT:
            begin
                cmd.sched_put = 1'b1;
                state_next    = trqs_pkg::FSM_SCHED_TAKE;
            end
            trqs_pkg::FSM_SCHED_TAKE:
            begin
                if (!status.ready_empty)
                begin
                    cmd.sched_take = 1'b1;
                    state_next     = trqs_pkg::FSM_FINISH;
                end
                else
                begin
                    cmd.walk_init  = 1'b1;
                    cmd.walk_sched = 1'b1;
                    state_next     = trqs_pkg::FSM_WALK;
                end
            end
            trqs_pkg::FSM_WALK:
            begin
                if (status.walk_last)
                begin
                    cmd.walk_end = 1'b1;
                    state_next   = trqs_pkg::FSM_FINISH;
                end
                else
                    cmd.walk_step = 1'b1;
            end
            trqs_pkg::FSM_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = trqs_pkg::FSM_IDLE;
                end
            end
            default:
                state_next = trqs_pkg::FSM_IDLE;
        endcase
    end

endmodule

// ===== rtl/trqs_dp.sv =====
// ----------------------------------------------------------------------------
// trqs_dp
// Slot tables, ready and other queues, walk unit and result register.
// ----------------------------------------------------------------------------
`include "thread_ready_queue_scheduler_macros.svh"

module trqs_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [trqs_pkg::BT_W-1:0]         cfg_wr_data,
    input  logic [trqs_pkg::REQ_W-1:0]        s_tuser,
    input  logic [trqs_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [trqs_pkg::M_DATA_W-1:0]     m_tdata,
    input  trqs_pkg::cmd_t                    cmd,
    output trqs_pkg::status_t                 status
);

    localparam int IW = trqs_pkg::IDX_W;
    localparam int CW = trqs_pkg::CNT_W;
    localparam int TW = trqs_pkg::TICK_W;
    localparam int N  = trqs_pkg::MAX_THREADS;

    // configuration
    logic [trqs_pkg::BT_W-1:0] bt_reg;

    // latched request
    logic [trqs_pkg::REQ_W-1:0] req_reg;
    logic [trqs_pkg::TID_W-1:0] tid_reg;
    logic [trqs_pkg::NS_W-1:0]  ns_reg;
    logic [TW-1:0]              sl_reg;
    logic [TW-1:0]              el_reg;

    // per-slot tables
    trqs_pkg::tstate_t slot_st[N];
    logic [TW-1:0]     slot_sl[N];

    // ready deque and other list, circular
    logic [IW-1:0] rq[N];
    logic [IW-1:0] oq[N];
    logic [IW-1:0] rh_reg, rh_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [IW-1:0] oh_reg, oh_next;
    logic [CW-1:0] oc_reg, oc_next;

    logic          run_valid_reg, run_valid_next;
    logic [IW-1:0] run_reg, run_next;

    // walk unit
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] w_reg, w_next;
    logic          wtick_reg;
    logic          wsched_reg;
    logic [TW-1:0] d_reg;

    logic err_reg, err_next;
    logic done_reg, done_next;

    // table write ports
    logic              st_we;
    logic [IW-1:0]     st_wa;
    trqs_pkg::tstate_t st_wd;
    logic              sl_we;
    logic [IW-1:0]     sl_wa;
    logic [TW-1:0]     sl_wd;
    logic              rq_we;
    logic [IW-1:0]     rq_wa;
    logic [IW-1:0]     rq_wd;
    logic              oq_we;
    logic [IW-1:0]     oq_wa;
    logic [IW-1:0]     oq_wd;

    // read side
    logic [IW-1:0]     st_ra;
    trqs_pkg::tstate_t st_rd;
    logic [TW-1:0]     sl_rd;
    logic [IW-1:0]     sid;
    logic              sid_ok;
    logic [IW-1:0]     walk_slot;
    logic [IW-1:0]     rtail;
    logic              wake;
    logic              move;
    logic              drop;
    logic [trqs_pkg::BT_W:0] lim;

    logic                        m_valid_reg;
    logic [trqs_pkg::M_DATA_W-1:0] m_data_reg;
    logic [CW+1:0]               occ_total;

    assign sid       = trqs_pkg::tid_to_slot(tid_reg);
    assign sid_ok    = trqs_pkg::tid_in_range(tid_reg);
    assign walk_slot = oq[trqs_pkg::ptr_add(oh_reg, i_reg)];
    assign rtail     = trqs_pkg::ptr_add(rh_reg, rc_reg);
    assign lim       = {bt_reg, 1'b0};

    always_comb
    begin
        priority if (cmd.sched_put)
            st_ra = run_reg;
        else if (cmd.walk_step)
            st_ra = walk_slot;
        else
            st_ra = sid;
    end
    assign st_rd = slot_st[st_ra];
    assign sl_rd = slot_sl[st_ra];

    assign status.req         = req_reg;
    assign status.ready_empty = (rc_reg == '0);
    assign status.walk_last   = (i_reg == oc_reg);
    assign status.out_free    = !m_valid_reg || m_tready;

    always_comb
    begin
        rh_next        = rh_reg;
        rc_next        = rc_reg;
        oh_next        = oh_reg;
        oc_next        = oc_reg;
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        i_next         = i_reg;
        w_next         = w_reg;
        err_next       = err_reg;
        done_next      = done_reg;
        st_we = 1'b0; st_wa = st_ra; st_wd = trqs_pkg::TS_READY;
        sl_we = 1'b0; sl_wa = st_ra; sl_wd = '0;
        rq_we = 1'b0; rq_wa = rtail; rq_wd = st_ra;
        oq_we = 1'b0; oq_wa = trqs_pkg::ptr_add(oh_reg, w_reg); oq_wd = walk_slot;
        wake  = 1'b0;
        move  = 1'b0;
        drop  = 1'b0;

        if (cmd.latch)
        begin
            err_next  = 1'b0;
            done_next = 1'b0;
        end

        if (cmd.do_admit)
        begin
            if (!sid_ok || st_rd != trqs_pkg::TS_FREE)
                err_next = 1'b1;
            else
            begin
                st_we   = 1'b1;
                sl_we   = 1'b1;
                rq_we   = 1'b1;
                rc_next = rc_reg + 1'b1;
            end
        end

        if (cmd.do_set)
        begin
            if (!sid_ok || st_rd == trqs_pkg::TS_FREE)
                err_next = 1'b1;
            else if (ns_reg <= 3'(trqs_pkg::TS_DEAD))
            begin
                st_we = 1'b1;
                st_wd = trqs_pkg::tstate_t'(ns_reg);
                if (ns_reg == 3'(trqs_pkg::TS_SLEEP))
                begin
                    sl_we = 1'b1;
                    sl_wd = sl_reg;
                end
            end
        end

        if (cmd.sched_put && run_valid_reg)
        begin
            run_valid_next = 1'b0;
            if (st_rd == trqs_pkg::TS_ACTIVE)
            begin
                st_we   = 1'b1;
                rq_we   = 1'b1;
                rc_next = rc_reg + 1'b1;
            end
            else
            begin
                // current thread goes to the front of the other list
                oh_next = trqs_pkg::ptr_dec(oh_reg);
                oq_we   = 1'b1;
                oq_wa   = oh_next;
                oq_wd   = run_reg;
                oc_next = oc_reg + 1'b1;
            end
        end

        if (cmd.sched_take)
        begin
            run_valid_next = 1'b1;
            run_next       = rq[rh_reg];
            st_we          = 1'b1;
            st_wa          = rq[rh_reg];
            st_wd          = trqs_pkg::TS_ACTIVE;
            rh_next        = trqs_pkg::ptr_add(rh_reg, CW'(1));
            rc_next        = rc_reg - 1'b1;
        end

        if (cmd.walk_init)
        begin
            i_next = '0;
            w_next = '0;
        end

        if (cmd.walk_step)
        begin
            i_next = i_reg + 1'b1;
            if (wtick_reg)
            begin
                if (st_rd == trqs_pkg::TS_SLEEP)
                begin
                    sl_we = 1'b1;
                    if (sl_rd > d_reg)
                        sl_wd = sl_rd - d_reg;
                    else
                    begin
                        wake  = 1'b1;
                        st_we = 1'b1;
                    end
                end
                move = wake || (st_rd == trqs_pkg::TS_READY);
            end
            else if (st_rd == trqs_pkg::TS_DEAD)
            begin
                drop  = 1'b1;
                st_we = 1'b1;
                st_wd = trqs_pkg::TS_FREE;
                sl_we = 1'b1;
            end

            if (move)
            begin
                // woken or ready: onto the front of the ready queue
                rh_next = trqs_pkg::ptr_dec(rh_reg);
                rq_we   = 1'b1;
                rq_wa   = rh_next;
                rc_next = rc_reg + 1'b1;
            end
            else if (!drop)
            begin
                oq_we  = 1'b1;
                w_next = w_reg + 1'b1;
            end
        end

        if (cmd.walk_end)
        begin
            oc_next = w_reg;
            if (wsched_reg)
                done_next = (w_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bt_reg        <= trqs_pkg::BACKUP_TIME_RST;
            rh_reg        <= '0;
            rc_reg        <= '0;
            oh_reg        <= '0;
            oc_reg        <= '0;
            run_valid_reg <= 1'b0;
            run_reg       <= '0;
            i_reg         <= '0;
            w_reg         <= '0;
            err_reg       <= 1'b0;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int k = 0; k < N; k++)
                slot_st[k] <= trqs_pkg::TS_FREE;
        end
        else
        begin
            if (cfg_wr_en)
                bt_reg <= cfg_wr_data;
            rh_reg        <= rh_next;
            rc_reg        <= rc_next;
            oh_reg        <= oh_next;
            oc_reg        <= oc_next;
            run_valid_reg <= run_valid_next;
            run_reg       <= run_next;
            i_reg         <= i_next;
            w_reg         <= w_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
            if (st_we)
                slot_st[st_wa] <= st_wd;
            if (cmd.load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= s_tuser;
            tid_reg <= s_tdata[3:0];
            ns_reg  <= s_tdata[6:4];
            sl_reg  <= s_tdata[38:7];
            el_reg  <= s_tdata[70:39];
        end
        if (cmd.walk_init)
        begin
            wtick_reg  <= cmd.walk_tick;
            wsched_reg <= cmd.walk_sched;
            // elapsed time clamped to twice the timer period
            d_reg      <= (el_reg > TW'(lim)) ? TW'(lim) : el_reg;
        end
        if (sl_we)
            slot_sl[sl_wa] <= sl_wd;
        if (rq_we)
            rq[rq_wa] <= rq_wd;
        if (oq_we)
            oq[oq_wa] <= oq_wd;
        if (cmd.load_out)
            m_data_reg <= {7'd0, err_reg, done_reg,
                           trqs_pkg::cnt_to_field(oc_reg),
                           trqs_pkg::cnt_to_field(rc_reg),
                           run_valid_reg ? trqs_pkg::slot_to_tid(run_reg) : 4'd0,
                           run_valid_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // during a walk, moved entries are already counted in rc but oc is only
    // settled at the end of the walk
    assign occ_total = (CW+2)'(rc_reg) + (CW+2)'(oc_reg) + (CW+2)'(run_valid_reg);

    `TRQS_ASSERT_IMPL(a_occupancy, clk, rst_n, !(cmd.walk_step || cmd.walk_end), occ_total <= (CW+2)'(N))
    `TRQS_ASSERT_IMPL(a_walk_compact, clk, rst_n, cmd.walk_step, w_reg <= i_reg)
    `TRQS_ASSERT_IMPL(a_out_free, clk, rst_n, cmd.load_out, !m_valid_reg || m_tready)
    `TRQS_ASSERT_NEXT(a_take_runs, clk, rst_n, cmd.sched_take, run_valid_reg)

endmodule

// ===== rtl/thread_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler
// Round-robin thread scheduler with sleep timers over a fixed set of slots.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives exactly one result beat showing
// the scheduler state after it. Admit, set-state and unknown requests go from
// dispatch straight to finish; schedule first puts back the running thread,
// then takes the head of the ready queue. Tick and purge walk the other list
// one entry per cycle, and so does a schedule that finds nothing ready. A
// result that is still held in the output register keeps the request waiting
// in the finish state. The next request is accepted as soon as the result is
// placed in the output register, even if that beat has not yet been taken.
// backup_time resets to 10 and is written by cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, the block itself does not enforce this.
module thread_ready_queue_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // backup_time
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,      // thread_id, new_state, sleep_ticks, elapsed_ticks
    input  logic [2:0]  s_tuser,      // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // current_valid, current_thread, ready_count,
                                      // other_count, all_done, req_error
);

    trqs_pkg::cmd_t    cmd;
    trqs_pkg::status_t status;

    trqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    trqs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - thread ready queue scheduler testbench
// Drives admit, set-state, schedule, tick and purge requests over the request
// stream, predicts the status beat of each request with a local list model and
// checks every returned beat field by field, under varying backup_time and
// random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [trqs_pkg::REQ_W-1:0] REQ_RSV5 = 3'd5;
    localparam logic [trqs_pkg::REQ_W-1:0] REQ_RSV6 = 3'd6;
    localparam logic [trqs_pkg::REQ_W-1:0] REQ_RSV7 = 3'd7;
    localparam logic [4:0]       NIL      = 5'd16;
    localparam int               LIMIT    = 400000;
    localparam int               N_DIR    = 25;

    typedef struct packed {
        logic [6:0] pad;
        logic       req_error;
        logic       all_done;
        logic [4:0] other_count;
        logic [4:0] ready_count;
        logic [3:0] current_thread;
        logic       current_valid;
    } sched_status_t;

    typedef struct {
        logic [trqs_pkg::REQ_W-1:0] req;
        logic [3:0]       tid;
        logic [2:0]       ns;
        logic [31:0]      sl;
        logic [31:0]      el;
        bit               typed;
        logic [23:0]      status;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    thread_ready_queue_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    // scheduler image
    logic [15:0] bt_shadow;
    logic [2:0]  st_img [16];
    logic [31:0] sleep_img [16];
    logic [4:0]  nxt [16];
    logic [4:0]  prv [16];
    logic [4:0]  rq_head, rq_tail, ot_head, run_slot;

    sched_status_t status_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_epoch = 0;
    int cycles = 0;
    dir_row_t dir [N_DIR];

    function automatic void unlink(bit is_ready, logic [4:0] s);
        logic [4:0] p, n;
        p = prv[s];
        n = nxt[s];
        if (p != NIL) nxt[p] = n;
        else if (is_ready) rq_head = n;
        else ot_head = n;
        if (n != NIL) prv[n] = p;
        else if (is_ready) rq_tail = p;
        nxt[s] = NIL;
        prv[s] = NIL;
    endfunction

    function automatic void ready_append(logic [4:0] s);
        nxt[s] = NIL;
        prv[s] = rq_tail;
        if (rq_tail != NIL) nxt[rq_tail] = s; else rq_head = s;
        rq_tail = s;
    endfunction

    function automatic void ready_prepend(logic [4:0] s);
        prv[s] = NIL;
        nxt[s] = rq_head;
        if (rq_head != NIL) prv[rq_head] = s; else rq_tail = s;
        rq_head = s;
    endfunction

    function automatic logic [4:0] chain_len(logic [4:0] s);
        logic [4:0] k;
        k = 0;
        while (s != NIL && k < 16) begin
            k++;
            s = nxt[s];
        end
        return k;
    endfunction

    function automatic void reap_dead();
        logic [4:0] s, n;
        int k;
        s = ot_head;
        k = 0;
        while (s != NIL && k < 16) begin
            n = nxt[s];
            if (st_img[s] == trqs_pkg::TS_DEAD) begin
                unlink(1'b0, s);
                st_img[s] = trqs_pkg::TS_FREE;
                sleep_img[s] = '0;
            end
            s = n;
            k++;
        end
    endfunction

    function automatic void reset_image();
        bt_shadow = trqs_pkg::BACKUP_TIME_RST;
        for (int i = 0; i < 16; i++) begin
            st_img[i] = trqs_pkg::TS_FREE;
            sleep_img[i] = '0;
            nxt[i] = NIL;
            prv[i] = NIL;
        end
        rq_head = NIL;
        rq_tail = NIL;
        ot_head = NIL;
        run_slot = NIL;
    endfunction

    function automatic sched_status_t schedule_step(logic [2:0] req, logic [3:0] tid,
                                                   logic [2:0] ns, logic [31:0] sl,
                                                   logic [31:0] el);
        sched_status_t r;
        logic [4:0] s, n, c;
        logic [31:0] lim, d;
        int k;
        r = '0;
        case (req)
            trqs_pkg::REQ_ADMIT: begin
                if (st_img[tid] != trqs_pkg::TS_FREE) r.req_error = 1'b1;
                else begin
                    st_img[tid] = trqs_pkg::TS_READY;
                    sleep_img[tid] = '0;
                    ready_append({1'b0, tid});
                end
            end
            trqs_pkg::REQ_SET: begin
                if (st_img[tid] == trqs_pkg::TS_FREE) r.req_error = 1'b1;
                else if (ns <= trqs_pkg::TS_DEAD) begin
                    st_img[tid] = ns;
                    if (ns == trqs_pkg::TS_SLEEP) sleep_img[tid] = sl;
                end
            end
            trqs_pkg::REQ_SCHED: begin
                if (run_slot != NIL) begin
                    c = run_slot;
                    run_slot = NIL;
                    if (st_img[c] == trqs_pkg::TS_ACTIVE) begin
                        st_img[c] = trqs_pkg::TS_READY;
                        ready_append(c);
                    end else begin
                        prv[c] = NIL;
                        nxt[c] = ot_head;
                        if (ot_head != NIL) prv[ot_head] = c;
                        ot_head = c;
                    end
                end
                if (rq_head != NIL) begin
                    c = rq_head;
                    unlink(1'b1, c);
                    st_img[c] = trqs_pkg::TS_ACTIVE;
                    run_slot = c;
                end else begin
                    reap_dead();
                    if (chain_len(ot_head) == 0) r.all_done = 1'b1;
                end
            end
            trqs_pkg::REQ_TICK: begin
                lim = {15'd0, bt_shadow, 1'b0};
                d = (el > lim) ? lim : el;
                s = ot_head;
                k = 0;
                while (s != NIL && k < 16) begin
                    if (st_img[s] == trqs_pkg::TS_SLEEP) begin
                        if (sleep_img[s] > d) sleep_img[s] -= d;
                        else begin
                            sleep_img[s] = '0;
                            st_img[s] = trqs_pkg::TS_READY;
                        end
                    end
                    s = nxt[s];
                    k++;
                end
                s = ot_head;
                k = 0;
                while (s != NIL && k < 16) begin
                    n = nxt[s];
                    if (st_img[s] == trqs_pkg::TS_READY) begin
                        unlink(1'b0, s);
                        ready_prepend(s);
                    end
                    s = n;
                    k++;
                end
            end
            trqs_pkg::REQ_PURGE: reap_dead();
            default: ;
        endcase
        r.current_valid = (run_slot != NIL);
        r.current_thread = (run_slot != NIL) ? run_slot[3:0] : 4'd0;
        r.ready_count = chain_len(rq_head);
        r.other_count = chain_len(ot_head);
        return r;
    endfunction

    task automatic send_req(logic [2:0] req, logic [3:0] tid, logic [2:0] ns,
                            logic [31:0] sl, logic [31:0] el, bit typed, logic [23:0] status);
        bit ok;
        sched_status_t p;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, el, sl, ns, tid};
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        p = schedule_step(req, tid, ns, sl, el);
        status_q.push_back(typed ? sched_status_t'(status) : p);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);  // walk may still be busy
    endtask

    task automatic write_backup(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        bt_shadow = v;
        @(posedge clk);
    endtask

    task automatic random_reqs(int count);
        logic [2:0] req, ns;
        logic [3:0] tid;
        logic [31:0] sl, el;
        int w, pick;
        for (int i = 0; i < count; i++) begin
            w = $urandom_range(99);
            if (w < 20) req = trqs_pkg::REQ_ADMIT;
            else if (w < 47) req = trqs_pkg::REQ_SET;
            else if (w < 72) req = trqs_pkg::REQ_SCHED;
            else if (w < 90) req = trqs_pkg::REQ_TICK;
            else if (w < 95) req = trqs_pkg::REQ_PURGE;
            else req = 3'($urandom_range(7, 5));
            tid = 4'($urandom);
            if (req == trqs_pkg::REQ_SET && $urandom_range(9) < 8) begin
                // prefer an occupied slot
                pick = $urandom_range(15);
                for (int j = 0; j < 16; j++)
                    if (st_img[(pick + j) % 16] != trqs_pkg::TS_FREE) begin
                        tid = 4'((pick + j) % 16);
                        break;
                    end
            end
            ns = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            sl = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(60));
            el = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(40));
            send_req(req, tid, ns, sl, el, 1'b0, '0);
        end
    endtask

    // receiver
    always @(posedge clk)
    begin : recv_proc
        static int hold_cnt = 0;
        static int seen_epoch = 0;
        if (seen_epoch != hold_epoch) begin
            seen_epoch = hold_epoch;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, int e, int a);
        if (e != a) begin
            errors++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
        end
    endtask

    always @(negedge clk)
    begin
        sched_status_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none actual %h", $time, m_tdata);
            end else begin
                want = status_q.pop_front();
                check_field("current_valid", want.current_valid, got.current_valid);
                check_field("current_thread", want.current_thread, got.current_thread);
                check_field("ready_count", want.ready_count, got.ready_count);
                check_field("other_count", want.other_count, got.other_count);
                check_field("all_done", want.all_done, got.all_done);
                check_field("req_error", want.req_error, got.req_error);
                check_field("pad", want.pad, got.pad);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        dir[0]  = '{trqs_pkg::REQ_SCHED, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b1,
                    24'h008000};
        dir[1]  = '{trqs_pkg::REQ_ADMIT, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b1,
                    24'h000020};
        dir[2]  = '{trqs_pkg::REQ_ADMIT, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b1,
                    24'h010020};
        dir[3]  = '{trqs_pkg::REQ_SET,   4'd5,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b1,
                    24'h010020};
        dir[4]  = '{trqs_pkg::REQ_ADMIT, 4'd15, trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[5]  = '{trqs_pkg::REQ_SCHED, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[6]  = '{trqs_pkg::REQ_SET,   4'd0,  trqs_pkg::TS_SLEEP,   32'hFFFFFFFF, 32'd0,
                    1'b0, 24'h0};
        dir[7]  = '{trqs_pkg::REQ_SCHED, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[8]  = '{trqs_pkg::REQ_TICK,  4'd0,  trqs_pkg::TS_READY,   32'd0, 32'hFFFFFFFF,
                    1'b0, 24'h0};
        dir[9]  = '{trqs_pkg::REQ_SET,   4'd15, 3'd7,                 32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[10] = '{REQ_RSV5,            4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[11] = '{REQ_RSV6,            4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[12] = '{REQ_RSV7,            4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[13] = '{trqs_pkg::REQ_SET,   4'd15, trqs_pkg::TS_DEAD,    32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[14] = '{trqs_pkg::REQ_SCHED, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[15] = '{trqs_pkg::REQ_SET,   4'd0,  trqs_pkg::TS_SLEEP,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[16] = '{trqs_pkg::REQ_TICK,  4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[17] = '{trqs_pkg::REQ_SCHED, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[18] = '{trqs_pkg::REQ_SET,   4'd0,  trqs_pkg::TS_BLOCKED, 32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[19] = '{trqs_pkg::REQ_ADMIT, 4'd3,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[20] = '{trqs_pkg::REQ_SET,   4'd3,  trqs_pkg::TS_DEAD,    32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[21] = '{trqs_pkg::REQ_SCHED, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[22] = '{trqs_pkg::REQ_SCHED, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[23] = '{trqs_pkg::REQ_PURGE, 4'd0,  trqs_pkg::TS_READY,   32'd0, 32'd0, 1'b0,
                    24'h0};
        dir[24] = '{trqs_pkg::REQ_ADMIT, 4'd15, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0,
                    24'h0};

        reset_image();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 66;
        foreach (dir[i])
            send_req(dir[i].req, dir[i].tid, dir[i].ns, dir[i].sl, dir[i].el,
                     dir[i].typed, dir[i].status);
        drain();

        write_backup(16'd1);
        random_reqs(290);
        drain();

        send_idle_pct = 66;
        recv_idle_pct = 30;
        write_backup(16'hFFFF);
        random_reqs(290);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_backup(16'($urandom_range(65535, 1)));
        hold_epoch++;  // long receiver stall while requests keep coming
        random_reqs(300);
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
